// ===== sv/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and pair decode helpers for the URL
// percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  // result slots held per request (worst case is the four-byte fallback)
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned CNT_W   = 3;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_BTICK = 8'h60;  // '`'
  localparam logic [7:0] CH_APOS  = 8'h27;  // '\''
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_USCR  = 8'h5F;  // '_'
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // escape progress
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } upd_phase_e;

  typedef logic [CNT_W-1:0] upd_cnt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       final_result;
  } upd_out_t;

  typedef upd_out_t [SLOTS-1:0] upd_slots_t;

  // escape state carried between requests
  typedef struct packed {
    upd_phase_e phase;
    logic [7:0] first_digit;
  } upd_esc_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // hex letter A-F / a-f: flag and value 10..15
  function automatic logic [4:0] hex_letter(input logic [7:0] c);
    logic hit;
    hit = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    return {hit, 4'd9 + {1'b0, c[2:0]}};
  endfunction

  function automatic logic plain_pass(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           is_dec(c) || (c == CH_DASH) || (c == CH_AMP) || (c == CH_DOT) ||
           (c == CH_EQ) || (c == CH_USCR);
  endfunction

  // whitelisted pair: {hit, decoded byte}
  function automatic logic [8:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] let_v;
    logic       let_ok;
    logic [3:0] let_n;
    logic       dig_ok;
    logic [3:0] dig_n;
    logic [8:0] res;
    let_v  = hex_letter(lo);
    let_ok = let_v[4];
    let_n  = let_v[3:0];
    dig_ok = is_dec(lo);
    dig_n  = lo[3:0];
    res    = '0;
    unique case (hi)
      8'h30: begin
        if (let_ok && (let_n == 4'd13)) res = {1'b1, CH_LF};
        else if (let_ok && (let_n == 4'd10)) res = {1'b1, CH_CR};
      end
      8'h32: begin
        if (dig_ok && (dig_n != 4'd0)) res = {1'b1, 4'h2, dig_n};
        else if (let_ok) res = {1'b1, 4'h2, let_n};
      end
      8'h33: begin
        if (let_ok) res = {1'b1, 4'h3, let_n};
      end
      8'h34: begin
        if (dig_ok && (dig_n == 4'd0)) res = {1'b1, 8'h40};
      end
      8'h35: begin
        if (let_ok && (let_n >= 4'd11)) res = {1'b1, 4'h5, let_n};
      end
      8'h36: begin
        if (dig_ok && (dig_n == 4'd0)) res = {1'b1, 8'h60};
      end
      8'h37: begin
        if (let_ok && (let_n >= 4'd11) && (let_n <= 4'd14)) res = {1'b1, 4'h7, let_n};
      end
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/upd_step.sv =====
// ----------------------------------------------------------------------------
// upd_step
// Decodes one request against the escape state: gives the result slots,
// their count and the next escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_step (
  input  upd_pkg::upd_in_t    req_i,
  input  upd_pkg::upd_esc_t   esc_i,
  output upd_pkg::upd_esc_t   esc_o,
  output upd_pkg::upd_slots_t slots_o,
  output upd_pkg::upd_cnt_t   cnt_o
);
  import upd_pkg::*;

  logic [8:0]  pair;
  logic [7:0]  c;
  upd_slots_t  slots;
  upd_cnt_t    cnt;

  assign c    = req_i.in_byte;
  assign pair = decode_pair(esc_i.first_digit, c);

  // byte classification and escape tracking
  always_comb begin
    slots = '0;
    cnt   = '0;
    esc_o = esc_i;
    unique case (esc_i.phase)
      PH_HI: begin
        esc_o.first_digit = c;
        esc_o.phase       = PH_LO;
      end
      PH_LO: begin
        esc_o.phase = PH_IDLE;
        if (pair[8]) begin
          slots[0] = '{out_byte: pair[7:0], byte_valid: 1'b1, final_result: 1'b0};
          cnt      = upd_cnt_t'(1);
        end else begin
          slots[0] = '{out_byte: CH_BTICK, byte_valid: 1'b1, final_result: 1'b0};
          slots[1] = '{out_byte: esc_i.first_digit, byte_valid: 1'b1, final_result: 1'b0};
          slots[2] = '{out_byte: c, byte_valid: 1'b1, final_result: 1'b0};
          slots[3] = '{out_byte: CH_APOS, byte_valid: 1'b1, final_result: 1'b0};
          cnt      = upd_cnt_t'(SLOTS);
        end
      end
      default: begin
        esc_o.phase = PH_IDLE;
        if (c == CH_PCT) begin
          esc_o.phase = PH_HI;
        end else if (c == CH_PLUS) begin
          slots[0] = '{out_byte: CH_SPACE, byte_valid: 1'b1, final_result: 1'b0};
          cnt      = upd_cnt_t'(1);
        end else if (plain_pass(c)) begin
          slots[0] = '{out_byte: c, byte_valid: 1'b1, final_result: 1'b0};
          cnt      = upd_cnt_t'(1);
        end
      end
    endcase

    // end of string: drop a pending escape, mark the last result
    if (req_i.end_of_text) begin
      esc_o.phase = PH_IDLE;
      if (cnt == '0) begin
        cnt = upd_cnt_t'(1);
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (upd_cnt_t'(i + 1) == cnt) slots[i].final_result = 1'b1;
      end
    end
  end

  assign slots_o = slots;
  assign cnt_o   = cnt;

endmodule

`default_nettype wire

// ===== sv/url_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// URL percent decoder: plain bytes filtered, '+' to space, %XY escapes
// decoded against a whitelist, unlisted pairs expanded to four bytes.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i / in_stall_o  | in_data_i  (in_byte, end_of_text)
//  out     | out_valid_o / out_stall_i| out_data_o (out_byte, byte_valid,
//          |                        |             final_result)
//
//  one request per cycle while each gives at most one result and the output is not stalled
//  an unlisted escape pair gives four results from the result buffer,
//  one a cycle unless the output stalls, holding off new requests while more than one waits
//  reset clears the escape state and empties the result buffer
//  a stalled output holds the buffer; input is taken again once the
//  buffer's last waiting result leaves
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  upd_pkg::upd_in_t     in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output upd_pkg::upd_out_t    out_data_o
);
  import upd_pkg::*;

  upd_esc_t   esc_q, esc_d, esc_next;
  upd_slots_t slot_q, slot_d, step_slots;
  upd_cnt_t   cnt_q, cnt_d, step_cnt;
  logic       in_acc;
  logic       out_pop;

  upd_step u_step (
    .req_i   (in_data_i),
    .esc_i   (esc_q),
    .esc_o   (esc_next),
    .slots_o (step_slots),
    .cnt_o   (step_cnt)
  );

  // handshake
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[0];
  assign out_pop     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > upd_cnt_t'(1)) || ((cnt_q == upd_cnt_t'(1)) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  // result buffer load and drain
  always_comb begin
    esc_d  = esc_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      esc_d  = esc_next;
      slot_d = step_slots;
      cnt_d  = step_cnt;
    end else if (out_pop) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
      slot_d[SLOTS-1] = '0;
      cnt_d           = cnt_q - upd_cnt_t'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= '{phase: PH_IDLE, first_digit: 8'h00};
      cnt_q <= '0;
    end else begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// ===== sv/upd_checker.sv =====
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input upd_pkg::upd_in_t  in_data_i,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input upd_pkg::upd_out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // the end of a string always yields a result next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_text |=> out_valid_o)
    else $error("end of string gave no result");

  // input is only held off while results wait
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  // a bare end marker is always the final result
  a_marker_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.final_result)
    else $error("bare marker without final flag");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (.*);

`default_nettype wire

// ===== sim/url_percent_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_core_test
// Self-checking bench for the URL percent decoder: directed strings for the
// pass-through, plus, drop and escape rules, then random well-formed and
// broken strings under source gaps and sink stalls, with a long sink hold-off
// that backs the core up. Every result is checked in order against a
// behavioral decode of each accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int REPORT_CAP    = 100;
  localparam int PHASE_ITEMS   = 65;

  // clock, reset and block ports
  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  upd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  upd_out_t out_data_o;

  // decoder state mirrored by the bench
  upd_phase_e esc_phase = PH_IDLE;
  logic [7:0] esc_first = '0;

  // decoded bytes still owed by the core, oldest first
  upd_out_t decoded_q[$];
  int       errors = 0;

  // idle rates and sink hold-off control
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;

  url_percent_decoder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // decode rules
  // ---------------------------------------------------------------------------

  // byte for a listed hex pair, or -1 when the pair is not listed
  function automatic int pair_code(input logic [7:0] hi, input logic [7:0] lo);
    int letv;
    int digv;
    letv = -1;
    digv = -1;
    if (lo >= "A" && lo <= "F") letv = int'(lo) - int'("A") + 10;
    if (lo >= "a" && lo <= "f") letv = int'(lo) - int'("a") + 10;
    if (lo >= "0" && lo <= "9") digv = int'(lo) - int'("0");
    case (hi)
      "0": begin
        // CR and LF come out swapped on purpose
        if (letv == 13) return 'h0A;
        if (letv == 10) return 'h0D;
      end
      "2": begin
        if (digv >= 1) return 'h20 + digv;
        if (letv >= 10) return 'h20 + letv;
      end
      "3": if (letv >= 10) return 'h30 + letv;
      "4": if (digv == 0) return 'h40;
      "5": if (letv >= 11) return 'h50 + letv;
      "6": if (digv == 0) return 'h60;
      "7": if (letv >= 11 && letv <= 14) return 'h70 + letv;
      default: ;
    endcase
    return -1;
  endfunction

  function automatic bit keeps_literal(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == CH_DASH || c == CH_AMP || c == CH_DOT || c == CH_EQ || c == CH_USCR;
  endfunction

  function automatic upd_out_t data_byte(input logic [7:0] b);
    upd_out_t r;
    r.out_byte     = b;
    r.byte_valid   = 1'b1;
    r.final_result = 1'b0;
    return r;
  endfunction

  // advance the mirrored state by one request and queue what it must produce
  function automatic void decode_request(input logic [7:0] b, input logic eot);
    upd_out_t burst[$];
    upd_out_t tail;
    int       code;
    case (esc_phase)
      PH_HI: begin
        esc_first = b;
        esc_phase = PH_LO;
      end
      PH_LO: begin
        code = pair_code(esc_first, b);
        if (code >= 0) begin
          burst.push_back(data_byte(code[7:0]));
        end else begin
          // unlisted pair is echoed between backtick and apostrophe
          burst.push_back(data_byte(CH_BTICK));
          burst.push_back(data_byte(esc_first));
          burst.push_back(data_byte(b));
          burst.push_back(data_byte(CH_APOS));
        end
        esc_phase = PH_IDLE;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (b == CH_PCT) esc_phase = PH_HI;
        else if (b == CH_PLUS) burst.push_back(data_byte(CH_SPACE));
        else if (keeps_literal(b)) burst.push_back(data_byte(b));
      end
    endcase
    if (eot) begin
      // end of string drops a pending escape and always marks a last result
      esc_phase = PH_IDLE;
      if (burst.size() == 0) begin
        tail = '0;
        burst.push_back(tail);
      end
      tail = burst.pop_back();
      tail.final_result = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) decoded_q.push_back(burst[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // source side
  // ---------------------------------------------------------------------------

  // offer one request from a falling edge, return at the falling edge after it is taken
  task automatic send_request(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.in_byte = b;
    in_data_i.end_of_text = eot;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    decode_request(b, eot);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_request(s[i], eot_last && (i == s.len() - 1));
  endtask

  // stop sending and wait until the core has handed over everything owed
  task automatic wait_drained();
    int spins;
    spins = 0;
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk_i);
      spins++;
    end
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, decoded_q.size());
      decoded_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sink side: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // compare each delivered byte with the oldest one owed
  always @(posedge clk_i) begin
    upd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t ns: unexpected result, expected none, got byte %02h valid %0b last %0b",
                   $time, out_data_o.out_byte, out_data_o.byte_valid,
                   out_data_o.final_result);
      end else begin
        want = decoded_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t ns: out_byte mismatch, expected %02h, got %02h",
                     $time, want.out_byte, out_data_o.out_byte);
        end
        if (out_data_o.byte_valid !== want.byte_valid) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t ns: byte_valid mismatch, expected %0b, got %0b",
                     $time, want.byte_valid, out_data_o.byte_valid);
        end
        if (out_data_o.final_result !== want.final_result) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t ns: final_result mismatch, expected %0b, got %0b",
                     $time, want.final_result, out_data_o.final_result);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random string material
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  // first pair digit leans toward the listed rows
  function automatic logic [7:0] rand_pair_head();
    string rows;
    rows = "0234567";
    if ($urandom_range(3) != 0) return rows[$urandom_range(rows.len() - 1)];
    return rand_hex_char();
  endfunction

  function automatic logic [7:0] rand_literal();
    string marks;
    marks = "-&.=_";
    case ($urandom_range(3))
      0: return 8'("A" + $urandom_range(25));
      1: return 8'("a" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return marks[$urandom_range(marks.len() - 1)];
    endcase
  endfunction

  // one string: mostly literals and escapes, some noise and cut-off escapes
  task automatic send_random_string(inout int useful);
    logic [7:0] bytes[$];
    int         kind;
    int         noise;
    noise = 0;
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(99);
      if (kind < 38) begin
        bytes.push_back(rand_literal());
      end else if (kind < 46) begin
        bytes.push_back(CH_PLUS);
      end else if (kind < 80) begin
        bytes.push_back(CH_PCT);
        bytes.push_back(rand_pair_head());
        bytes.push_back(rand_hex_char());
      end else if (kind < 88) begin
        bytes.push_back(CH_PCT);
        bytes.push_back(8'($urandom_range(255)));
        bytes.push_back(8'($urandom_range(255)));
      end else begin
        bytes.push_back(8'($urandom_range(255)));
        noise++;
      end
    end
    // string cut short inside an escape
    case ($urandom_range(9))
      0: bytes.push_back(CH_PCT);
      1: begin
        bytes.push_back(CH_PCT);
        bytes.push_back(rand_pair_head());
      end
      default: ;
    endcase
    foreach (bytes[i]) send_request(bytes[i], i == bytes.size() - 1);
    useful += bytes.size() - noise;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // literals, plus, dropped bytes, field extremes and a bare end marker
  task automatic test_plain_bytes();
    send_text("Az+", 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
    send_text("_", 1'b1);
    wait_drained();
  endtask

  // listed pairs, the CR/LF swap, an unlisted pair and escapes cut by the end
  task automatic test_escapes();
    send_text("%0D%0a", 1'b0);
    send_text("%7e", 1'b1);
    send_text("%Zq", 1'b1);
    send_text("%4", 1'b1);
    send_text("%", 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int target);
    int useful;
    useful = 0;
    send_idle_pct = src_pct;
    stall_pct = snk_pct;
    while (useful < target) send_random_string(useful);
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // long sink hold-off while the source keeps offering, then a full pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_seq++;
    send_text("%zz+ab%G1%7B%0Q-x%3f%99.", 1'b1);
    wait_drained();
    hold_seq++;
    send_text("%20%40%5b=%60%Fe_", 1'b1);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_plain_bytes();
    test_escapes();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(47, 0, PHASE_ITEMS);
    test_random_traffic(0, 47, PHASE_ITEMS);
    test_random_traffic(26, 26, PHASE_ITEMS);
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/upd_pkg.sv
sv/upd_step.sv
sv/url_percent_decoder_core.sv
sv/upd_checker.sv
sim/url_percent_decoder_core_test.sv
